>>> rtl/bnf_pkg.sv
// bnf_pkg: shared types and constants of the box iou nms filter
// used by the interfaces, the iou compare pipeline and the top level
// no dependencies

package bnf_pkg;

	// coordinate width of one box edge, signed q12.4
	localparam int COORD_W = 16;

	// one pixel in q12.4, added to every inclusive extent
	localparam int ONE_PIXEL = 16;

	// threshold width and its value after reset (0.5 in q0.16)
	localparam int THR_W = 16;
	localparam logic [THR_W-1:0] THR_RESET = 16'h8000;

	// output field widths
	localparam int INDEX_W = 12;
	localparam int COUNT_W = 9;

	// one stored box, x1 in the low bits
	typedef struct packed {
		logic signed [COORD_W-1:0] y2;
		logic signed [COORD_W-1:0] x2;
		logic signed [COORD_W-1:0] y1;
		logic signed [COORD_W-1:0] x1;
	} box_t;

	localparam int BOX_W = $bits(box_t);

	// one finished pair comparison from the iou pipeline
	typedef struct packed {
		logic valid;
		logic suppress;
	} cmp_res_t;

endpackage

>>> rtl/bnf_box_if.sv
// bnf_box_if: valid/ready channel that carries one input box
// depends on bnf_pkg for the coordinate width

interface bnf_box_if;
	logic                                valid;
	logic                                ready;
	logic signed [bnf_pkg::COORD_W-1:0]  box_x1;
	logic signed [bnf_pkg::COORD_W-1:0]  box_y1;
	logic signed [bnf_pkg::COORD_W-1:0]  box_x2;
	logic signed [bnf_pkg::COORD_W-1:0]  box_y2;
	logic                                last_box;

	modport source (
		output valid, box_x1, box_y1, box_x2, box_y2, last_box,
		input  ready
	);

	modport sink (
		input  valid, box_x1, box_y1, box_x2, box_y2, last_box,
		output ready
	);
endinterface

>>> rtl/bnf_res_if.sv
// bnf_res_if: valid/ready channel that carries one suppression result
// depends on bnf_pkg for the field widths

interface bnf_res_if;
	logic                           valid;
	logic                           ready;
	logic [bnf_pkg::INDEX_W-1:0]    box_index;
	logic                           kept;
	logic [bnf_pkg::COUNT_W-1:0]    kept_count;
	logic                           set_done;
	logic                           overflow;

	modport source (
		output valid, box_index, kept, kept_count, set_done, overflow,
		input  ready
	);

	modport sink (
		input  valid, box_index, kept, kept_count, set_done, overflow,
		output ready
	);
endinterface

>>> rtl/bnf_ram.sv
// bnf_ram: generic single write port, single read port ram
// read data is registered; no dependencies

module bnf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]     waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]     raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/bnf_iou_pipe.sv
// bnf_iou_pipe: pipelined overlap test of the current box against one stored box a cycle
// depends on bnf_pkg for box_t and cmp_res_t

module bnf_iou_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bnf_pkg::box_t                 cur,
	input  logic [bnf_pkg::THR_W-1:0]     thr,
	input  logic                          rd_en,
	input  bnf_pkg::box_t                 other,
	output bnf_pkg::cmp_res_t             res
);

	// stage 0 marks the cycle in which ram data is valid
	logic v_s0, v_s1, v_s2, v_s3, v_s4;

	logic signed [17:0] hi_x, lo_x, hi_y, lo_y, dw, dh;
	logic [16:0]        w_s1, h_s1;
	logic signed [17:0] ewb_s1, ehb_s1, ewa_s1, eha_s1;
	logic [33:0]        inter_s2, inter_s3, inter_s4;
	logic signed [35:0] sb_s2, sa_s2;
	logic signed [36:0] uni_s3;
	logic               pos_s4;
	logic [49:0]        prod_s4;

	// intersection edges, sign extended to leave room for the pixel add
	always_comb begin
		hi_x = (cur.x2 < other.x2) ? 18'(cur.x2) : 18'(other.x2);
		lo_x = (cur.x1 > other.x1) ? 18'(cur.x1) : 18'(other.x1);
		hi_y = (cur.y2 < other.y2) ? 18'(cur.y2) : 18'(other.y2);
		lo_y = (cur.y1 > other.y1) ? 18'(cur.y1) : 18'(other.y1);
		dw   = hi_x - lo_x + 18'(bnf_pkg::ONE_PIXEL);
		dh   = hi_y - lo_y + 18'(bnf_pkg::ONE_PIXEL);
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s0 <= rd_en;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: clamped intersection extents and box extents
	always_ff @(posedge clk) begin
		w_s1   <= dw[17] ? '0 : dw[16:0];
		h_s1   <= dh[17] ? '0 : dh[16:0];
		ewb_s1 <= 18'(other.x2) - 18'(other.x1) + 18'(bnf_pkg::ONE_PIXEL);
		ehb_s1 <= 18'(other.y2) - 18'(other.y1) + 18'(bnf_pkg::ONE_PIXEL);
		ewa_s1 <= 18'(cur.x2) - 18'(cur.x1) + 18'(bnf_pkg::ONE_PIXEL);
		eha_s1 <= 18'(cur.y2) - 18'(cur.y1) + 18'(bnf_pkg::ONE_PIXEL);
	end

	// stage 2: intersection and box areas
	always_ff @(posedge clk) begin
		inter_s2 <= w_s1 * h_s1;
		sb_s2    <= ewb_s1 * ehb_s1;
		sa_s2    <= ewa_s1 * eha_s1;
	end

	// stage 3: union
	always_ff @(posedge clk) begin
		uni_s3   <= 37'(sa_s2) + 37'(sb_s2) - $signed({3'b000, inter_s2});
		inter_s3 <= inter_s2;
	end

	// stage 4: threshold times union, positive union stays below 2^34
	always_ff @(posedge clk) begin
		pos_s4   <= !uni_s3[36] && (uni_s3 != '0);
		prod_s4  <= thr * uni_s3[33:0];
		inter_s4 <= inter_s3;
	end

	// final compare, inter * 65536 against thr * union
	always_comb begin
		res.valid    = v_s4;
		res.suppress = pos_s4 && ({inter_s4, 16'h0000} > prod_s4);
	end

endmodule

>>> rtl/box_iou_nms_filter_top.sv
// box_iou_nms_filter_top: greedy iou non-maximum suppression over sorted boxes
// depends on bnf_pkg, bnf_box_if, bnf_res_if, bnf_ram and bnf_iou_pipe

// Boxes come in one per transfer, sorted by falling score, and each gets one
// result: its index in the set, a keep flag, the running kept count, a set end
// flag and an overflow flag. The kept store is read one stored box per cycle
// into a compare path (ram read and four pipeline stages), then the scan
// closes and the result posts once the output register is free. With an empty
// store nothing is read, and boxes past the index range skip the scan. The
// input opens again in the cycle after a post. The block takes the next box
// while the previous result waits in the output register. The threshold is
// to be written through cfg_wr_en and cfg_wr_data while no box is in work;
// the user is bound to this, the block itself does not enforce it. It resets
// to 0.5.

module box_iou_nms_filter_top #(
	parameter int MAX_KEPT  = 256,
	parameter int MAX_BOXES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bnf_pkg::THR_W-1:0]     cfg_wr_data,
	bnf_box_if.sink                       box_in,
	bnf_res_if.source                     res_out
);

	localparam int AW = $clog2(MAX_KEPT > 1 ? MAX_KEPT : 2);
	localparam int KW = $clog2(MAX_KEPT + 1);
	localparam int PW = $clog2(MAX_BOXES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                      state_q;
	bnf_pkg::box_t               cur_q;
	logic                        last_q;
	logic                        pos_ovf_q;
	logic                        supp_q;
	logic [KW-1:0]               kept_total_q;
	logic [KW-1:0]               scan_q;
	logic [KW-1:0]               done_q;
	logic [PW-1:0]               pos_q;
	logic [bnf_pkg::THR_W-1:0]   thr_q;

	logic                        out_valid_q;
	logic [bnf_pkg::INDEX_W-1:0] out_index_q;
	logic                        out_kept_q;
	logic [bnf_pkg::COUNT_W-1:0] out_count_q;
	logic                        out_done_q;
	logic                        out_ovf_q;

	logic                        in_fire;
	logic                        out_free;
	logic                        post;
	logic                        keep;
	logic                        full;
	logic                        rd_en;
	logic                        wr_en;
	logic                        scan_end;
	logic [KW-1:0]               new_total;
	logic [31:0]                 idx_wide;
	logic [31:0]                 cnt_wide;
	bnf_pkg::box_t               other;
	bnf_pkg::cmp_res_t           cmp;

	// handshake and decision terms
	always_comb begin
		in_fire   = box_in.valid && box_in.ready;
		out_free  = !out_valid_q || res_out.ready;
		post      = (state_q == ST_DONE) && out_free;
		keep      = !pos_ovf_q && !supp_q;
		full      = (kept_total_q == KW'(MAX_KEPT));
		wr_en     = post && keep && !full;
		new_total = wr_en ? kept_total_q + KW'(1) : kept_total_q;
		rd_en     = (state_q == ST_SCAN) && (scan_q != kept_total_q);
		scan_end  = (state_q == ST_SCAN) && (scan_q == kept_total_q)
		            && (done_q == kept_total_q);
		idx_wide  = pos_ovf_q ? 32'(MAX_BOXES - 1) : 32'(pos_q);
		cnt_wide  = 32'(new_total);
	end

	assign box_in.ready       = (state_q == ST_IDLE);
	assign res_out.valid      = out_valid_q;
	assign res_out.box_index  = out_index_q;
	assign res_out.kept       = out_kept_q;
	assign res_out.kept_count = out_count_q;
	assign res_out.set_done   = out_done_q;
	assign res_out.overflow   = out_ovf_q;

	// kept box store, read during the scan, written when a kept box posts and the store is not full
	bnf_ram #(
		.WIDTH (bnf_pkg::BOX_W),
		.DEPTH (MAX_KEPT)
	) u_kept_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (kept_total_q[AW-1:0]),
		.wdata (cur_q),
		.re    (rd_en),
		.raddr (scan_q[AW-1:0]),
		.rdata (other)
	);

	// overlap test of the current box against each stored box
	bnf_iou_pipe u_iou_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.cur    (cur_q),
		.thr    (thr_q),
		.rd_en  (rd_en),
		.other  (other),
		.res    (cmp)
	);

	// control state, set counters and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_q       <= 1'b0;
			pos_ovf_q    <= 1'b0;
			supp_q       <= 1'b0;
			kept_total_q <= '0;
			scan_q       <= '0;
			done_q       <= '0;
			pos_q        <= '0;
			thr_q        <= bnf_pkg::THR_RESET;
			out_valid_q  <= 1'b0;
			out_index_q  <= '0;
			out_kept_q   <= 1'b0;
			out_count_q  <= '0;
			out_done_q   <= 1'b0;
			out_ovf_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (res_out.ready && !post) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						last_q    <= box_in.last_box;
						pos_ovf_q <= (pos_q == PW'(MAX_BOXES));
						supp_q    <= 1'b0;
						scan_q    <= '0;
						done_q    <= '0;
						state_q   <= (pos_q == PW'(MAX_BOXES)) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						scan_q <= scan_q + KW'(1);
					end
					if (cmp.valid) begin
						done_q <= done_q + KW'(1);
						supp_q <= supp_q || cmp.suppress;
					end
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_index_q <= idx_wide[bnf_pkg::INDEX_W-1:0];
						out_kept_q  <= keep;
						out_count_q <= cnt_wide[bnf_pkg::COUNT_W-1:0];
						out_done_q  <= last_q;
						out_ovf_q   <= pos_ovf_q || (keep && full);
						if (last_q) begin
							kept_total_q <= '0;
							pos_q        <= '0;
						end else begin
							kept_total_q <= new_total;
							if (!pos_ovf_q) begin
								pos_q <= pos_q + PW'(1);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// box payload capture, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cur_q.x1 <= box_in.box_x1;
			cur_q.y1 <= box_in.box_y1;
			cur_q.x2 <= box_in.box_x2;
			cur_q.y2 <= box_in.box_y2;
		end
	end

endmodule

>>> rtl/bnf_checker.sv
// bnf_checker: port level assertions on the box iou nms filter
// bound to box_iou_nms_filter_top; depends on bnf_pkg for field widths

module bnf_checker #(
	parameter int MAX_BOXES = 4096
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bnf_pkg::INDEX_W-1:0]   box_index,
	input logic                          kept,
	input logic [bnf_pkg::COUNT_W-1:0]   kept_count,
	input logic                          set_done,
	input logic                          overflow
);

	// one box in work at a time: a box transfer closes the input
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a box transfer");

	// a stalled result holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(box_index) && $stable(kept)
		&& $stable(kept_count) && $stable(set_done) && $stable(overflow))
		else $error("stalled result changed");

	// a box past the index range is dropped at the top index
	a_range_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow && !kept |-> box_index == bnf_pkg::INDEX_W'(MAX_BOXES - 1))
		else $error("dropped box shows wrong index");

	// a kept box counts itself
	a_kept_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kept && !overflow |-> kept_count != '0)
		else $error("kept box with zero kept count");

endmodule

bind box_iou_nms_filter_top bnf_checker #(
	.MAX_BOXES (MAX_BOXES)
) u_bnf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (box_in.valid),
	.in_ready   (box_in.ready),
	.out_valid  (res_out.valid),
	.out_ready  (res_out.ready),
	.box_index  (res_out.box_index),
	.kept       (res_out.kept),
	.kept_count (res_out.kept_count),
	.set_done   (res_out.set_done),
	.overflow   (res_out.overflow)
);

>>> test/box_iou_nms_filter_top_test.sv
// box_iou_nms_filter_top_test: self-checking bench for the greedy iou suppression filter
// predicts every result from its own model of the kept list and checks each result transfer
// depends on bnf_pkg, bnf_box_if, bnf_res_if and box_iou_nms_filter_top

`timescale 1ns / 1ps

module box_iou_nms_filter_top_test;

	localparam int MAX_KEPT   = 256;
	localparam int MAX_BOXES  = 4096;
	localparam int MAX_REPORT = 10;

	// one result as the output channel carries it
	typedef struct packed {
		logic [bnf_pkg::INDEX_W-1:0] box_index;
		logic                        kept;
		logic [bnf_pkg::COUNT_W-1:0] kept_count;
		logic                        set_done;
		logic                        overflow;
	} nms_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [bnf_pkg::THR_W-1:0] cfg_wr_data;

	bnf_box_if box_ch ();
	bnf_res_if res_ch ();

	box_iou_nms_filter_top #(
		.MAX_KEPT  (MAX_KEPT),
		.MAX_BOXES (MAX_BOXES)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.box_in      (box_ch),
		.res_out     (res_ch)
	);

	// predictor state: kept list, counters and threshold
	bnf_pkg::box_t             kept_list [MAX_KEPT];
	int                        kept_total;
	int                        box_pos;
	logic [bnf_pkg::THR_W-1:0] overlap_thr;

	nms_result_t   pending_results [$];
	int            mismatch_count;
	int            sender_idle_pct;
	int            receiver_stall_pct;
	bnf_pkg::box_t prev_box;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#100_000_000;
		$display("FAIL box_iou_nms_filter_top");
		$finish;
	end

	function automatic longint coord(logic [bnf_pkg::COORD_W-1:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint lmin(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	function automatic longint lmax(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic bnf_pkg::box_t make_box(int x1, int y1, int x2, int y2);
		bnf_pkg::box_t b;
		b.x1 = 16'(x1);
		b.y1 = 16'(y1);
		b.x2 = 16'(x2);
		b.y2 = 16'(y2);
		return b;
	endfunction

	// division-free iou test: does prior suppress cand
	function automatic logic overlap_exceeds(bnf_pkg::box_t cand, bnf_pkg::box_t prior,
			logic [bnf_pkg::THR_W-1:0] thr);
		longint w, h, inter, area_cand, area_prior, uni;
		w = lmin(coord(cand.x2), coord(prior.x2)) - lmax(coord(cand.x1), coord(prior.x1))
			+ bnf_pkg::ONE_PIXEL;
		h = lmin(coord(cand.y2), coord(prior.y2)) - lmax(coord(cand.y1), coord(prior.y1))
			+ bnf_pkg::ONE_PIXEL;
		if (w < 0) w = 0;
		if (h < 0) h = 0;
		inter = w * h;
		area_cand  = (coord(cand.x2) - coord(cand.x1) + bnf_pkg::ONE_PIXEL)
			* (coord(cand.y2) - coord(cand.y1) + bnf_pkg::ONE_PIXEL);
		area_prior = (coord(prior.x2) - coord(prior.x1) + bnf_pkg::ONE_PIXEL)
			* (coord(prior.y2) - coord(prior.y1) + bnf_pkg::ONE_PIXEL);
		uni = area_cand + area_prior - inter;
		if (uni <= 0) return 1'b0;
		return (inter * 65536) > (longint'(thr) * uni);
	endfunction

	// greedy suppression step: result for one box, updates the kept list
	function automatic nms_result_t suppress_step(bnf_pkg::box_t b, logic last);
		nms_result_t r;
		logic        keep;
		int          k;
		r = '0;
		if (box_pos >= MAX_BOXES) begin
			r.box_index = bnf_pkg::INDEX_W'(MAX_BOXES - 1);
			r.overflow  = 1'b1;
		end else begin
			r.box_index = bnf_pkg::INDEX_W'(box_pos);
			box_pos++;
			keep = 1'b1;
			for (k = 0; k < kept_total && keep; k++) begin
				if (overlap_exceeds(b, kept_list[k], overlap_thr)) keep = 1'b0;
			end
			if (keep) begin
				if (kept_total >= MAX_KEPT) begin
					r.overflow = 1'b1;
				end else begin
					kept_list[kept_total] = b;
					kept_total++;
				end
			end
			r.kept = keep;
		end
		r.kept_count = bnf_pkg::COUNT_W'(kept_total);
		r.set_done   = last;
		if (last) begin
			kept_total = 0;
			box_pos    = 0;
		end
		return r;
	endfunction

	// receiver: random stall and result check
	always @(posedge clk) begin : result_check
		nms_result_t seen, want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			seen.box_index  = res_ch.box_index;
			seen.kept       = res_ch.kept;
			seen.kept_count = res_ch.kept_count;
			seen.set_done   = res_ch.set_done;
			seen.overflow   = res_ch.overflow;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORT)
					$display("%0t unexpected result transfer:", $realtime,
						" idx %0d kept %0b count %0d done %0b ovf %0b",
						seen.box_index, seen.kept, seen.kept_count,
						seen.set_done, seen.overflow);
			end else begin
				want = pending_results.pop_front();
				if (seen.box_index !== want.box_index || seen.kept !== want.kept
						|| seen.kept_count !== want.kept_count
						|| seen.set_done !== want.set_done
						|| seen.overflow !== want.overflow) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORT)
						$display("%0t mismatch: expected", $realtime,
							" idx %0d kept %0b count %0d done %0b ovf %0b,",
							want.box_index, want.kept, want.kept_count,
							want.set_done, want.overflow,
							" got idx %0d kept %0b count %0d done %0b ovf %0b",
							seen.box_index, seen.kept, seen.kept_count,
							seen.set_done, seen.overflow);
				end
			end
		end
		res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// one box transfer, optional idle cycles first
	task automatic send_box(input bnf_pkg::box_t b, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			box_ch.valid <= 1'b0;
			@(posedge clk);
		end
		box_ch.valid    <= 1'b1;
		box_ch.box_x1   <= b.x1;
		box_ch.box_y1   <= b.y1;
		box_ch.box_x2   <= b.x2;
		box_ch.box_y2   <= b.y2;
		box_ch.last_box <= last;
		do @(posedge clk); while (box_ch.ready !== 1'b1);
		pending_results.push_back(suppress_step(b, last));
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain_results();
		box_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// threshold write, only with the block idle
	task automatic write_threshold(input logic [bnf_pkg::THR_W-1:0] value);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		overlap_thr = value;
		@(posedge clk);
	endtask

	function automatic logic [bnf_pkg::THR_W-1:0] pick_threshold();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return bnf_pkg::THR_W'($urandom_range(65535));
			default: return bnf_pkg::THR_W'($urandom_range(52000, 16384));
		endcase
	endfunction

	// mostly clustered boxes, some shifted copies, full-range noise and inverted boxes
	function automatic bnf_pkg::box_t random_box();
		bnf_pkg::box_t b;
		int            sel, x1, y1;
		sel = $urandom_range(99);
		x1  = int'($urandom_range(1023)) - 512;
		y1  = int'($urandom_range(1023)) - 512;
		if (sel < 50) begin
			b = make_box(x1, y1, x1 + int'($urandom_range(400)), y1 + int'($urandom_range(400)));
		end else if (sel < 70) begin
			b = make_box(int'(coord(prev_box.x1)) + int'($urandom_range(40)) - 20,
				int'(coord(prev_box.y1)) + int'($urandom_range(40)) - 20,
				int'(coord(prev_box.x2)) + int'($urandom_range(40)) - 20,
				int'(coord(prev_box.y2)) + int'($urandom_range(40)) - 20);
		end else if (sel < 85) begin
			b = bnf_pkg::box_t'({$urandom(), $urandom()});
		end else begin
			b = make_box(x1, y1, x1 - int'($urandom_range(300)), y1 + int'($urandom_range(300)) - 100);
		end
		prev_box = b;
		return b;
	endfunction

	// default threshold: identical, partly overlapping and disjoint boxes
	task automatic check_default_threshold_overlap();
		send_box(make_box(0, 0, 159, 159), 1'b0);
		send_box(make_box(0, 0, 159, 159), 1'b0);
		send_box(make_box(80, 0, 239, 159), 1'b0);
		send_box(make_box(2000, 2000, 2100, 2100), 1'b1);
	endtask

	// zero threshold suppresses any overlap, full threshold only near-identical boxes
	task automatic check_threshold_extremes();
		write_threshold('0);
		send_box(make_box(0, 0, 159, 159), 1'b0);
		send_box(make_box(160, 0, 319, 159), 1'b0);
		send_box(make_box(159, 159, 300, 300), 1'b1);
		write_threshold('1);
		send_box(make_box(0, 0, 159, 159), 1'b0);
		send_box(make_box(0, 0, 159, 159), 1'b0);
		send_box(make_box(0, 0, 159, 175), 1'b1);
		write_threshold(bnf_pkg::THR_RESET);
	endtask

	// inverted and zero-extent boxes: non-positive union never suppresses
	task automatic check_degenerate_boxes();
		send_box(make_box(100, 100, 0, 200), 1'b0);
		send_box(make_box(100, 100, 0, 200), 1'b0);
		send_box(make_box(50, 50, 34, 34), 1'b0);
		send_box(make_box(50, 50, 34, 34), 1'b1);
	endtask

	// coordinate extremes
	task automatic check_extreme_coordinates();
		send_box(make_box(-32768, -32768, 32767, 32767), 1'b0);
		send_box(make_box(32767, 32767, 32767, 32767), 1'b0);
		send_box(make_box(-32768, -32768, -32768, -32768), 1'b0);
		send_box(make_box(-32768, -32768, 32767, 32767), 1'b0);
		send_box(make_box(32767, -32768, -32768, 32767), 1'b1);
	endtask

	// fill the kept store, then surviving boxes flag overflow
	task automatic check_kept_store_full();
		int i, x, y;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		for (i = 0; i < MAX_KEPT + 1; i++) begin
			x = (i % 16) * 64;
			y = (i / 16) * 64;
			send_box(make_box(x, y, x + 15, y + 15), 1'b0);
		end
		send_box(make_box(0, 0, 15, 15), 1'b0);
		send_box(make_box(4000, 4000, 4015, 4015), 1'b1);
	endtask

	// run past the index range within one set, then check the clear
	task automatic check_index_limit();
		int i;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		for (i = 0; i < MAX_BOXES + 2; i++)
			send_box(make_box(-500, -500, -300, -300), 1'b0);
		send_box(make_box(1000, 1000, 1200, 1200), 1'b1);
		send_box(make_box(1000, 1000, 1200, 1200), 1'b1);
	endtask

	// random sets under one idling mix, threshold sometimes changed between sets
	task automatic check_random_sets(input int idle_pct, input int stall_pct, input int item_goal);
		int sent, set_len, i;
		drain_results();
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		write_threshold(pick_threshold());
		sent = 0;
		while (sent < item_goal) begin
			set_len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(16, 1);
			for (i = 0; i < set_len; i++)
				send_box(random_box(), i == set_len - 1);
			sent += set_len;
			if ($urandom_range(99) < 8) write_threshold(pick_threshold());
			else if ($urandom_range(99) < 3) drain_results();
		end
	endtask

	// main sequence
	initial begin
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		box_ch.valid       = 1'b0;
		box_ch.box_x1      = '0;
		box_ch.box_y1      = '0;
		box_ch.box_x2      = '0;
		box_ch.box_y2      = '0;
		box_ch.last_box    = 1'b0;
		kept_total         = 0;
		box_pos            = 0;
		overlap_thr        = bnf_pkg::THR_RESET;
		mismatch_count     = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		prev_box           = make_box(0, 0, 100, 100);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_default_threshold_overlap();
		check_threshold_extremes();
		check_degenerate_boxes();
		check_extreme_coordinates();
		check_kept_store_full();
		check_index_limit();
		check_random_sets(0, 0, 360);
		check_random_sets(62, 0, 360);
		check_random_sets(0, 62, 360);
		check_random_sets(27, 27, 360);

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS box_iou_nms_filter_top");
		else
			$display("FAIL box_iou_nms_filter_top");
		$finish;
	end

endmodule

>>> sim.f
rtl/bnf_pkg.sv
rtl/bnf_box_if.sv
rtl/bnf_res_if.sv
rtl/bnf_ram.sv
rtl/bnf_iou_pipe.sv
rtl/box_iou_nms_filter_top.sv
rtl/bnf_checker.sv
test/box_iou_nms_filter_top_test.sv
